// ----- rtl/core/hsv_to_rgb_converter_defines.svh -----
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define HSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define HSV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSV_ASSERT(label, prop, msg)
`define HSV_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- rtl/core/hsv_pkg.sv -----
// Shared types and constants for the HSV to RGB converter.
package hsv_pkg;

  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;
  localparam int REM_W = 6;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [HUE_W-1:0] HUE_WRAP   = 9'd360;
  localparam logic [HUE_W-1:0] SECTOR_DEG = 9'd60;
  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [REM_W-1:0] REM_LIMIT  = 6'd60;
  localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;

  // Elaboration-time table constants.
  localparam longint PCT_FULL   = 100;
  localparam longint PCT_ROUND  = 50;
  localparam longint SEC_SPAN   = 60;
  localparam longint SEC_ROUND  = 30;
  localparam longint REM_TOP    = 59;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // One classified pixel as handed from front to back.
  typedef struct packed {
    sector_t          sector;
    logic [REM_W-1:0] rem;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
  } pix_t;

endpackage

// ----- rtl/core/hsv_front.sv -----
// Front end: hue wrap, sector split and percent clamping of an input beat.
module hsv_front (
  input  logic                        in_valid,
  input  logic [hsv_pkg::HUE_W-1:0]   in_hue_degrees,
  input  logic [hsv_pkg::PCT_W-1:0]   in_saturation_percent,
  input  logic [hsv_pkg::PCT_W-1:0]   in_value_percent,
  input  logic                        q_full,
  output logic                        in_stall,
  output logic                        push,
  output hsv_pkg::pix_t               pix
);

  logic [hsv_pkg::HUE_W-1:0] hue_w;
  logic [hsv_pkg::HUE_W-1:0] base;
  logic [hsv_pkg::HUE_W-1:0] diff;
  hsv_pkg::sector_t          sector;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    // Field tops at 511: one subtraction covers the whole range.
    hue_w = (in_hue_degrees >= hsv_pkg::HUE_WRAP) ?
            in_hue_degrees - hsv_pkg::HUE_WRAP : in_hue_degrees;
    if (hue_w >= 9'd300) begin
      sector = hsv_pkg::SEC_5;
      base   = 9'd300;
    end else if (hue_w >= 9'd240) begin
      sector = hsv_pkg::SEC_4;
      base   = 9'd240;
    end else if (hue_w >= 9'd180) begin
      sector = hsv_pkg::SEC_3;
      base   = 9'd180;
    end else if (hue_w >= 9'd120) begin
      sector = hsv_pkg::SEC_2;
      base   = 9'd120;
    end else if (hue_w >= hsv_pkg::SECTOR_DEG) begin
      sector = hsv_pkg::SEC_1;
      base   = hsv_pkg::SECTOR_DEG;
    end else begin
      sector = hsv_pkg::SEC_0;
      base   = '0;
    end
    diff = hue_w - base;

    pix.sector = sector;
    pix.rem    = diff[hsv_pkg::REM_W-1:0];
    pix.sat    = (in_saturation_percent > hsv_pkg::PCT_MAX) ?
                 hsv_pkg::PCT_MAX : in_saturation_percent;
    pix.val    = (in_value_percent > hsv_pkg::PCT_MAX) ?
                 hsv_pkg::PCT_MAX : in_value_percent;
  end

endmodule

// ----- rtl/core/hsv_queue.sv -----
// Two-entry queue between front and back.
module hsv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hsv_pkg::pix_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output hsv_pkg::pix_t head
);

  localparam int DEPTH = hsv_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hsv_pkg::pix_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/hsv_back.sv -----
// Back end: fixed-point p/q/t pipeline, sector pick and byte scaling.
module hsv_back #(
  parameter int F = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  hsv_pkg::pix_t              q_head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hsv_pkg::CH_W-1:0]   out_red,
  output logic [hsv_pkg::CH_W-1:0]   out_green,
  output logic [hsv_pkg::CH_W-1:0]   out_blue
);

  localparam int     XW        = F + 1;
  localparam int     PW        = 2 * F + 2;
  localparam int     BW        = F + hsv_pkg::CH_W + 1;
  localparam int     PCT_LUT_N = 2 ** hsv_pkg::PCT_W;
  localparam int     REM_LUT_N = 2 ** hsv_pkg::REM_W;
  localparam longint ONE_L     = longint'(1) << F;
  localparam logic [XW-1:0] ONE  = XW'(1) << F;
  localparam logic [XW-1:0] HALF = XW'(1) << (F - 1);

  typedef logic [XW-1:0] pct_lut_t [PCT_LUT_N];
  typedef logic [XW-1:0] rem_lut_t [REM_LUT_N];

  function automatic pct_lut_t build_pct_lut();
    pct_lut_t lut;
    longint   k;
    for (int i = 0; i < PCT_LUT_N; i++) begin
      k      = (longint'(i) > hsv_pkg::PCT_FULL) ? hsv_pkg::PCT_FULL : longint'(i);
      lut[i] = XW'((k * ONE_L + hsv_pkg::PCT_ROUND) / hsv_pkg::PCT_FULL);
    end
    return lut;
  endfunction

  function automatic rem_lut_t build_rem_lut();
    rem_lut_t lut;
    longint   k;
    for (int i = 0; i < REM_LUT_N; i++) begin
      k      = (longint'(i) > hsv_pkg::REM_TOP) ? hsv_pkg::REM_TOP : longint'(i);
      lut[i] = XW'((k * ONE_L + hsv_pkg::SEC_ROUND) / hsv_pkg::SEC_SPAN);
    end
    return lut;
  endfunction

  localparam pct_lut_t PCT_LUT = build_pct_lut();
  localparam rem_lut_t REM_LUT = build_rem_lut();

  // Q1.F product with round to nearest; operands are at most ONE.
  function automatic logic [XW-1:0] fx_mul(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [PW-1:0] prod;
    prod = PW'(a) * PW'(b) + PW'(HALF);
    return prod[2*F:F];
  endfunction

  // x * 255 as a shift and subtract, rounded, capped at 255.
  function automatic logic [hsv_pkg::CH_W-1:0] to_byte(input logic [XW-1:0] x);
    logic [BW-1:0]            w;
    logic [hsv_pkg::CH_W:0]   r;
    w = (BW'(x) << hsv_pkg::CH_W) - BW'(x) + BW'(HALF);
    r = w[BW-1:F];
    return (r > {1'b0, hsv_pkg::CH_MAX}) ? hsv_pkg::CH_MAX : r[hsv_pkg::CH_W-1:0];
  endfunction

  logic en;

  // stage 1: table lookups
  logic             s1_valid_r;
  hsv_pkg::sector_t s1_sector_r;
  logic [XW-1:0]    s1_s_r;
  logic [XW-1:0]    s1_v_r;
  logic [XW-1:0]    s1_f_r;

  // stage 2: first products
  logic             s2_valid_r;
  hsv_pkg::sector_t s2_sector_r;
  logic [XW-1:0]    s2_v_r;
  logic [XW-1:0]    s2_p_r;
  logic [XW-1:0]    s2_sf_r;
  logic [XW-1:0]    s2_sg_r;
  logic [XW-1:0]    s2_p_nxt;
  logic [XW-1:0]    s2_sf_nxt;
  logic [XW-1:0]    s2_sg_nxt;

  // stage 3: q and t
  logic             s3_valid_r;
  hsv_pkg::sector_t s3_sector_r;
  logic [XW-1:0]    s3_v_r;
  logic [XW-1:0]    s3_p_r;
  logic [XW-1:0]    s3_q_r;
  logic [XW-1:0]    s3_t_r;
  logic [XW-1:0]    s3_q_nxt;
  logic [XW-1:0]    s3_t_nxt;

  // stage 4: output register
  logic                     out_valid_r;
  logic [hsv_pkg::CH_W-1:0] red_r;
  logic [hsv_pkg::CH_W-1:0] green_r;
  logic [hsv_pkg::CH_W-1:0] blue_r;
  logic [XW-1:0]            r_sel;
  logic [XW-1:0]            g_sel;
  logic [XW-1:0]            b_sel;

  assign en  = !(out_valid_r && out_stall);
  assign pop = en && q_valid;

  assign s2_p_nxt  = fx_mul(s1_v_r, ONE - s1_s_r);
  assign s2_sf_nxt = fx_mul(s1_s_r, s1_f_r);
  assign s2_sg_nxt = fx_mul(s1_s_r, ONE - s1_f_r);

  assign s3_q_nxt = fx_mul(s2_v_r, ONE - s2_sf_r);
  assign s3_t_nxt = fx_mul(s2_v_r, ONE - s2_sg_r);

  // Zero saturation needs no own path: p, q and t all equal v then.
  always_comb begin
    case (s3_sector_r)
      hsv_pkg::SEC_1: begin
        r_sel = s3_q_r; g_sel = s3_v_r; b_sel = s3_p_r;
      end
      hsv_pkg::SEC_2: begin
        r_sel = s3_p_r; g_sel = s3_v_r; b_sel = s3_t_r;
      end
      hsv_pkg::SEC_3: begin
        r_sel = s3_p_r; g_sel = s3_q_r; b_sel = s3_v_r;
      end
      hsv_pkg::SEC_4: begin
        r_sel = s3_t_r; g_sel = s3_p_r; b_sel = s3_v_r;
      end
      hsv_pkg::SEC_5: begin
        r_sel = s3_v_r; g_sel = s3_p_r; b_sel = s3_q_r;
      end
      default: begin
        r_sel = s3_v_r; g_sel = s3_t_r; b_sel = s3_p_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sector_r <= q_head.sector;
      s1_s_r      <= PCT_LUT[q_head.sat];
      s1_v_r      <= PCT_LUT[q_head.val];
      s1_f_r      <= REM_LUT[q_head.rem];

      s2_sector_r <= s1_sector_r;
      s2_v_r      <= s1_v_r;
      s2_p_r      <= s2_p_nxt;
      s2_sf_r     <= s2_sf_nxt;
      s2_sg_r     <= s2_sg_nxt;

      s3_sector_r <= s2_sector_r;
      s3_v_r      <= s2_v_r;
      s3_p_r      <= s2_p_r;
      s3_q_r      <= s3_q_nxt;
      s3_t_r      <= s3_t_nxt;

      red_r       <= to_byte(r_sel);
      green_r     <= to_byte(g_sel);
      blue_r      <= to_byte(b_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// ----- rtl/core/hsv_to_rgb_converter.sv -----
// Top level of the HSV to RGB pixel converter.
//
//   channel  dir  handshake           beat payload
//   in_      in   in_valid/in_stall   hue_degrees[8:0], saturation_percent[6:0],
//                                     value_percent[6:0]
//   out_     out  out_valid/out_stall red[7:0], green[7:0], blue[7:0]
//
// Throughput: one beat per clock in and out, sustained while no finished beat waits on out_stall.
// Path: each input beat passes the queue, then the back-end chain: table
//   lookup, two dependent Q1.F products, byte scaling.
// Reset (rst_n low, synchronous) empties the queue and all pipeline valids.
// out_stall freezes the whole back end while a finished beat waits; the front keeps
//   taking beats until the two-entry queue is full, and only then raises in_stall.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input beat
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [hsv_pkg::HUE_W-1:0] in_hue_degrees,
  input  logic [hsv_pkg::PCT_W-1:0] in_saturation_percent,
  input  logic [hsv_pkg::PCT_W-1:0] in_value_percent,
  // output beat
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [hsv_pkg::CH_W-1:0]  out_red,
  output logic [hsv_pkg::CH_W-1:0]  out_green,
  output logic [hsv_pkg::CH_W-1:0]  out_blue
);

  // front -> queue
  logic          push;
  hsv_pkg::pix_t front_pix;
  logic          q_full;

  // queue -> back
  logic          q_valid;
  hsv_pkg::pix_t q_head;
  logic          pop;

  // Front: wraps hue past 360, splits into sector and remainder degrees,
  // clamps saturation and value to 100. Purely combinational.
  hsv_front u_front (
    .in_valid              (in_valid),
    .in_hue_degrees        (in_hue_degrees),
    .in_saturation_percent (in_saturation_percent),
    .in_value_percent      (in_value_percent),
    .q_full                (q_full),
    .in_stall              (in_stall),
    .push                  (push),
    .pix                   (front_pix)
  );

  // Short queue so the input side keeps moving while the output is held.
  hsv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_pix),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Back: four register stages, one shared enable that drops only while a
  // finished beat waits on out_stall.
  hsv_back #(
    .F (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  // The queue can only fill up behind a stalled output.
  `HSV_ASSERT(a_stall_needs_backpressure, in_stall |-> $past(out_valid && out_stall), "in_stall without output backpressure")

  // Remainder within a sector stays below 60 degrees after the hue wrap.
  `HSV_ASSERT(a_rem_in_sector, push |-> (front_pix.rem < hsv_pkg::REM_LIMIT), "hue remainder out of sector")

  // Reset leaves both channels quiet.
  `HSV_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_valid && !in_stall), "channels active after reset")

endmodule

// ----- bench/hsv_to_rgb_checker.sv -----
// Pixel checker: watches both channels, predicts RGB per accepted beat, compares.
`timescale 1ns / 1ps

module hsv_to_rgb_checker #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [hsv_pkg::HUE_W-1:0] in_hue_degrees,
  input  logic [hsv_pkg::PCT_W-1:0] in_saturation_percent,
  input  logic [hsv_pkg::PCT_W-1:0] in_value_percent,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [hsv_pkg::CH_W-1:0]  out_red,
  input  logic [hsv_pkg::CH_W-1:0]  out_green,
  input  logic [hsv_pkg::CH_W-1:0]  out_blue,
  output int                        mismatch_count,
  output int                        pixels_pending,
  output int                        pixels_checked
);

  localparam longint unsigned FX_UNIT = 64'd1 << FRACTION_BITS;
  localparam longint unsigned FX_RND  = 64'd1 << (FRACTION_BITS - 1);

  typedef struct packed {
    logic [hsv_pkg::CH_W-1:0] red;
    logic [hsv_pkg::CH_W-1:0] green;
    logic [hsv_pkg::CH_W-1:0] blue;
  } rgb_t;

  rgb_t rgb_expected[$];
  int   bad_beats   = 0;
  int   waiting     = 0;
  int   checked     = 0;

  assign mismatch_count = bad_beats;
  assign pixels_pending = waiting;
  assign pixels_checked = checked;

  function automatic longint unsigned fx_product(longint unsigned a, longint unsigned b);
    return (a * b + FX_RND) >> FRACTION_BITS;
  endfunction

  function automatic logic [hsv_pkg::CH_W-1:0] fx_to_channel(longint unsigned x);
    longint unsigned scaled;
    scaled = (x * hsv_pkg::CH_MAX + FX_RND) >> FRACTION_BITS;
    if (scaled > hsv_pkg::CH_MAX) scaled = hsv_pkg::CH_MAX;
    return hsv_pkg::CH_W'(scaled);
  endfunction

  // Q1.F HSV to RGB with rounding at every product.
  function automatic rgb_t convert_hsv(logic [hsv_pkg::HUE_W-1:0] hue_in,
                                       logic [hsv_pkg::PCT_W-1:0] sat_in,
                                       logic [hsv_pkg::PCT_W-1:0] val_in);
    longint unsigned hue, sat, val, s_fx, v_fx, f_fx, p_fx, q_fx, t_fx;
    longint unsigned r_fx, g_fx, b_fx;
    logic [2:0]      sec_idx;
    rgb_t            px;
    hue = hue_in;
    sat = sat_in;
    val = val_in;
    if (hue >= hsv_pkg::HUE_WRAP) hue -= hsv_pkg::HUE_WRAP;
    if (sat > hsv_pkg::PCT_MAX) sat = hsv_pkg::PCT_MAX;
    if (val > hsv_pkg::PCT_MAX) val = hsv_pkg::PCT_MAX;
    s_fx = (sat * FX_UNIT + hsv_pkg::PCT_ROUND) / hsv_pkg::PCT_FULL;
    v_fx = (val * FX_UNIT + hsv_pkg::PCT_ROUND) / hsv_pkg::PCT_FULL;
    if (s_fx == 0) begin
      r_fx = v_fx;
      g_fx = v_fx;
      b_fx = v_fx;
    end else begin
      sec_idx = 3'(hue / hsv_pkg::SECTOR_DEG);
      f_fx = ((hue % hsv_pkg::SEC_SPAN) * FX_UNIT + hsv_pkg::SEC_ROUND) / hsv_pkg::SEC_SPAN;
      p_fx = fx_product(v_fx, FX_UNIT - s_fx);
      q_fx = fx_product(v_fx, FX_UNIT - fx_product(s_fx, f_fx));
      t_fx = fx_product(v_fx, FX_UNIT - fx_product(s_fx, FX_UNIT - f_fx));
      case (hsv_pkg::sector_t'(sec_idx))
        hsv_pkg::SEC_1: begin r_fx = q_fx; g_fx = v_fx; b_fx = p_fx; end
        hsv_pkg::SEC_2: begin r_fx = p_fx; g_fx = v_fx; b_fx = t_fx; end
        hsv_pkg::SEC_3: begin r_fx = p_fx; g_fx = q_fx; b_fx = v_fx; end
        hsv_pkg::SEC_4: begin r_fx = t_fx; g_fx = p_fx; b_fx = v_fx; end
        hsv_pkg::SEC_5: begin r_fx = v_fx; g_fx = p_fx; b_fx = q_fx; end
        default: begin r_fx = v_fx; g_fx = t_fx; b_fx = p_fx; end
      endcase
    end
    px.red   = fx_to_channel(r_fx);
    px.green = fx_to_channel(g_fx);
    px.blue  = fx_to_channel(b_fx);
    return px;
  endfunction

  // Compare before push: a beat out can never belong to the beat in on the same edge.
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rgb_expected.size() == 0) begin
          $error("unexpected pixel out: r=%0d g=%0d b=%0d", out_red, out_green, out_blue);
          bad_beats <= bad_beats + 1;
        end else begin
          want = rgb_expected.pop_front();
          checked <= checked + 1;
          if (want.red !== out_red) $error("red: expected %0d, got %0d", want.red, out_red);
          if (want.green !== out_green)
            $error("green: expected %0d, got %0d", want.green, out_green);
          if (want.blue !== out_blue)
            $error("blue: expected %0d, got %0d", want.blue, out_blue);
          if (want !== {out_red, out_green, out_blue}) bad_beats <= bad_beats + 1;
        end
      end
      if (in_valid && !in_stall)
        rgb_expected.push_back(convert_hsv(in_hue_degrees, in_saturation_percent,
                                           in_value_percent));
      waiting <= rgb_expected.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the HSV to RGB bench: clock, reset, pixel stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int FRACTION_BITS = 16;
  localparam int RANDOM_PIXELS = 1030;
  localparam int QUIET_TAIL    = 150;   // last beats run with no gaps and no stalls

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [hsv_pkg::HUE_W-1:0] in_hue_degrees = '0;
  logic [hsv_pkg::PCT_W-1:0] in_saturation_percent = '0;
  logic [hsv_pkg::PCT_W-1:0] in_value_percent = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [hsv_pkg::CH_W-1:0]  out_red;
  logic [hsv_pkg::CH_W-1:0]  out_green;
  logic [hsv_pkg::CH_W-1:0]  out_blue;

  int mismatch_count;
  int pixels_pending;
  int pixels_checked;

  bit quiet = 1'b0;        // set for the closing stretch: both sides flat out
  int pace_mode = 0;       // 0: no idling, 1: light, 2: heavy; reshuffled whenever pace_timer runs out
  int stall_left = 0;
  int pace_timer = 0;
  int beats_sent = 0;

  always #1 clk = ~clk;

  hsv_to_rgb_converter #(.FRACTION_BITS(FRACTION_BITS)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_hue_degrees        (in_hue_degrees),
    .in_saturation_percent (in_saturation_percent),
    .in_value_percent      (in_value_percent),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_red               (out_red),
    .out_green             (out_green),
    .out_blue              (out_blue)
  );

  hsv_to_rgb_checker #(.FRACTION_BITS(FRACTION_BITS)) pixel_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_hue_degrees        (in_hue_degrees),
    .in_saturation_percent (in_saturation_percent),
    .in_value_percent      (in_value_percent),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_red               (out_red),
    .out_green             (out_green),
    .out_blue              (out_blue),
    .mismatch_count        (mismatch_count),
    .pixels_pending        (pixels_pending),
    .pixels_checked        (pixels_checked)
  );

  // Receiver back-pressure: random bursts of out_stall. The pace mode is redrawn
  // whenever pace_timer runs out, so that some windows see no stall at all and
  // others see a lot, which moves the stalls across every pipeline stage.
  always @(posedge clk) begin
    if (pace_timer == 0) begin
      pace_mode  <= $urandom_range(0, 2);
      pace_timer <= 127;
    end else begin
      pace_timer <= pace_timer - 1;
    end
    if (quiet || pace_mode == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, (pace_mode == 2) ? 3 : 15) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one pixel beat and hold it until the block takes it. A gap, when
  // drawn, drops valid first; valid is never dropped and raised in one step.
  task automatic send_pixel(logic [hsv_pkg::HUE_W-1:0] hue, logic [hsv_pkg::PCT_W-1:0] sat,
                            logic [hsv_pkg::PCT_W-1:0] val);
    int gap;
    gap = 0;
    if (!quiet && pace_mode != 0 && $urandom_range(0, (pace_mode == 2) ? 2 : 10) == 0)
      gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_hue_degrees        <= hue;
    in_saturation_percent <= sat;
    in_value_percent      <= val;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Sender goes quiet and waits for the pipeline to empty completely.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
  endtask

  // Safety net against a hung handshake.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [hsv_pkg::HUE_W-1:0] hue;
    logic [hsv_pkg::PCT_W-1:0] sat;
    logic [hsv_pkg::PCT_W-1:0] val;
    int                        pick;
    int                        waited;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sector borders, wrap at and above a full turn, grey, clamps.
    send_pixel(9'd0,   7'd100, 7'd100);   // pure red, zero fraction
    send_pixel(9'd59,  7'd100, 7'd100);   // end of first sector
    send_pixel(9'd60,  7'd100, 7'd100);
    send_pixel(9'd119, 7'd100, 7'd100);
    send_pixel(9'd120, 7'd100, 7'd100);
    send_pixel(9'd180, 7'd100, 7'd100);
    send_pixel(9'd240, 7'd100, 7'd100);
    send_pixel(9'd300, 7'd100, 7'd100);
    send_pixel(9'd359, 7'd100, 7'd100);
    send_pixel(9'd360, 7'd100, 7'd100);   // full turn wraps to red
    send_pixel(9'd361, 7'd50,  7'd80);    // above a full turn
    send_pixel(9'd511, 7'd127, 7'd127);   // all ones: wrap plus both clamps
    send_pixel(9'd200, 7'd0,   7'd73);    // grey
    send_pixel(9'd0,   7'd0,   7'd0);     // black
    send_pixel(9'd90,  7'd0,   7'd100);   // white
    send_pixel(9'd45,  7'd1,   7'd1);     // smallest nonzero s and v
    send_pixel(9'd150, 7'd101, 7'd60);    // saturation just over range
    send_pixel(9'd210, 7'd70,  7'd101);   // value just over range
    send_pixel(9'd270, 7'd100, 7'd0);     // saturated but dark
    send_pixel(9'd330, 7'd33,  7'd66);
    send_pixel(9'd1,   7'd99,  7'd99);
    send_pixel(9'd256, 7'd64,  7'd64);
    drain_pipeline();

    // Random: mostly legal pixels, some full-field values, some on the corners.
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == RANDOM_PIXELS / 2) drain_pipeline();
      if (n == RANDOM_PIXELS - QUIET_TAIL) quiet = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
        hue = 9'($urandom_range(0, 360));
        sat = 7'($urandom_range(0, 100));
        val = 7'($urandom_range(0, 100));
      end else if (pick < 19) begin
        hue = 9'($urandom_range(0, 511));
        sat = 7'($urandom_range(0, 127));
        val = 7'($urandom_range(0, 127));
      end else begin
        hue = 9'($urandom_range(0, 6) * 60);
        sat = ($urandom_range(0, 1) != 0) ? 7'd100 : 7'd0;
        val = ($urandom_range(0, 1) != 0) ? 7'd100 : 7'd0;
      end
      send_pixel(hue, sat, val);
    end
    in_valid <= 1'b0;

    // Let the pipeline empty, then keep clocking to catch stray beats.
    waited = 0;
    while (pixels_pending != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (pixels_pending != 0) $error("%0d pixels never came out", pixels_pending);
    repeat (16) @(posedge clk);

    $display("Sent %0d pixels, checked %0d: all hue sectors, grey, wrap and clamp cases,",
             beats_sent, pixels_checked);
    $display("under random input gaps and output stalls plus a flat-out tail.");
    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
